// File: rtl/core/lir_pkg.sv
// ----------------------------------------------------------------------------
// lir_pkg
// Shared constants and types of the linear interpolation resampler.
// ----------------------------------------------------------------------------
package lir_pkg;

  localparam int PHASE_FRAC_BITS = 14;
  localparam int SAMPLE_WIDTH    = 16;
  localparam int STEP_WIDTH      = 20;
  localparam int PHASE_WIDTH     = 21;
  localparam int MAX_RESULTS     = 64;

  // interpolator widths
  localparam int DIFF_WIDTH = SAMPLE_WIDTH + 1;
  localparam int FRAC_WIDTH = PHASE_FRAC_BITS + 1;
  localparam int PROD_WIDTH = DIFF_WIDTH + FRAC_WIDTH;
  localparam int SUM_WIDTH  = PROD_WIDTH - PHASE_FRAC_BITS;

  localparam logic [PHASE_WIDTH-1:0] PHASE_ONE =
    PHASE_WIDTH'(1) << PHASE_FRAC_BITS;
  localparam logic [STEP_WIDTH-1:0] STEP_RESET =
    STEP_WIDTH'(1) << PHASE_FRAC_BITS;
  localparam logic [STEP_WIDTH-1:0] MIN_STEP =
    STEP_WIDTH'((1 << PHASE_FRAC_BITS) / MAX_RESULTS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_OUT
  } state_t;

endpackage

// File: rtl/core/lir_interp.sv
// ----------------------------------------------------------------------------
// lir_interp
// Shared interpolator: registered (curr - prev) * frac, then prev + (p >>> F).
// ----------------------------------------------------------------------------
module lir_interp (
  input  logic                                        clk,
  input  logic                                        mul_en,
  input  logic signed [lir_pkg::SAMPLE_WIDTH-1:0]     prev,
  input  logic signed [lir_pkg::SAMPLE_WIDTH-1:0]     curr,
  input  logic        [lir_pkg::PHASE_FRAC_BITS-1:0]  frac,
  output logic signed [lir_pkg::SAMPLE_WIDTH-1:0]     result
);

  logic signed [lir_pkg::DIFF_WIDTH-1:0] diff;
  logic signed [lir_pkg::FRAC_WIDTH-1:0] frac_s;
  logic signed [lir_pkg::PROD_WIDTH-1:0] prod;
  logic signed [lir_pkg::SUM_WIDTH-1:0]  sum;

  assign diff   = lir_pkg::DIFF_WIDTH'(curr) - lir_pkg::DIFF_WIDTH'(prev);
  assign frac_s = $signed({1'b0, frac});

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= diff * frac_s;
    end
  end

  // prev*(1-ph) + curr*ph == prev*one + (curr-prev)*ph, floor shift
  assign sum    = lir_pkg::SUM_WIDTH'(prev)
                + prod[lir_pkg::PROD_WIDTH-1:lir_pkg::PHASE_FRAC_BITS];
  assign result = sum[lir_pkg::SAMPLE_WIDTH-1:0];

endmodule

// File: rtl/core/linear_interp_resampler_top.sv
// ----------------------------------------------------------------------------
// linear_interp_resampler_top
// Linear interpolation sample rate converter with a 14-bit fraction phase.
// ----------------------------------------------------------------------------
// A source sample with phase at or above one is accepted from idle and gives
// nothing. Otherwise each output takes a multiply step, then an add and
// register step, on the one shared multiplier; output stalls hold the add
// step. The first output is registered from ST_OUT after ST_MUL, once the
// source transaction has been accepted.
// Synchronous active-high reset clears phase, history and valids, step to one.
module linear_interp_resampler_top (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_we,
  input  logic        [lir_pkg::STEP_WIDTH-1:0]    cfg_wdata,
  input  logic                                     src_valid,
  output logic                                     src_stall,
  input  logic signed [lir_pkg::SAMPLE_WIDTH-1:0]  source_sample,
  output logic                                     res_valid,
  input  logic                                     res_stall,
  output logic signed [lir_pkg::SAMPLE_WIDTH-1:0]  out_sample,
  output logic                                     last_of_run
);

  lir_pkg::state_t state, state_next;

  logic        [lir_pkg::STEP_WIDTH-1:0]   phase_step;
  logic        [lir_pkg::STEP_WIDTH-1:0]   step_eff;
  logic        [lir_pkg::PHASE_WIDTH-1:0]  phase;
  logic        [lir_pkg::PHASE_WIDTH-1:0]  phase_sum;
  logic signed [lir_pkg::SAMPLE_WIDTH-1:0] previous_sample;
  logic signed [lir_pkg::SAMPLE_WIDTH-1:0] current_sample;
  logic signed [lir_pkg::SAMPLE_WIDTH-1:0] interp;

  logic src_take;
  logic out_free;
  logic load_out;
  logic mul_en;
  logic phase_low;
  logic run_end;

  assign step_eff  = (phase_step < lir_pkg::MIN_STEP) ? lir_pkg::MIN_STEP : phase_step;
  assign phase_sum = phase + lir_pkg::PHASE_WIDTH'(step_eff);
  assign phase_low = phase < lir_pkg::PHASE_ONE;
  assign run_end   = phase_sum >= lir_pkg::PHASE_ONE;
  assign out_free  = !res_valid || !res_stall;
  assign src_take  = src_valid && !src_stall;

  lir_interp u_interp (
    .clk    (clk),
    .mul_en (mul_en),
    .prev   (previous_sample),
    .curr   (current_sample),
    .frac   (phase[lir_pkg::PHASE_FRAC_BITS-1:0]),
    .result (interp)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lir_pkg::ST_IDLE: begin
        if (src_valid && phase_low) state_next = lir_pkg::ST_MUL;
      end
      lir_pkg::ST_MUL: begin
        state_next = lir_pkg::ST_OUT;
      end
      lir_pkg::ST_OUT: begin
        if (out_free) state_next = run_end ? lir_pkg::ST_IDLE : lir_pkg::ST_MUL;
      end
      default: state_next = lir_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    src_stall = 1'b1;
    mul_en    = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      lir_pkg::ST_IDLE: src_stall = 1'b0;
      lir_pkg::ST_MUL:  mul_en    = 1'b1;
      lir_pkg::ST_OUT:  load_out  = out_free;
      default: src_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= lir_pkg::ST_IDLE;
      phase_step      <= lir_pkg::STEP_RESET;
      phase           <= '0;
      previous_sample <= '0;
      current_sample  <= '0;
      res_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) phase_step <= cfg_wdata;

      if (src_take) begin
        previous_sample <= current_sample;
        current_sample  <= source_sample;
        // phase at or above one: no outputs, only drop by one
        if (!phase_low) phase <= phase - lir_pkg::PHASE_ONE;
      end

      if (load_out) begin
        phase <= run_end ? (phase_sum - lir_pkg::PHASE_ONE) : phase_sum;
      end

      if (load_out) res_valid <= 1'b1;
      else if (!res_stall) res_valid <= 1'b0;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_sample  <= interp;
      last_of_run <= run_end;
    end
  end

endmodule

// File: bench/resample_checker.sv
// ----------------------------------------------------------------------------
// resample_checker
// Watches the configuration port and both streams of the resampler, predicts
// the interpolated output samples and compares them in order.
// ----------------------------------------------------------------------------
module resample_checker
  import lir_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic        [STEP_WIDTH-1:0]   cfg_wdata,
  input  logic                           src_valid,
  input  logic                           src_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] source_sample,
  input  logic                           res_valid,
  input  logic                           res_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] out_sample,
  input  logic                           last_of_run,
  output int                             mismatches,
  output int                             outstanding
);

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           last;
  } interp_out_t;

  interp_out_t expected_samples[$];

  logic        [STEP_WIDTH-1:0]   step_reg;
  logic        [PHASE_WIDTH-1:0]  phase_acc;
  logic signed [SAMPLE_WIDTH-1:0] hist_prev;
  logic signed [SAMPLE_WIDTH-1:0] hist_curr;
  int                             err_count = 0;

  assign mismatches = err_count;

  initial outstanding = 0;

  // shift the history, then emit one interpolated sample per step while
  // the phase is below one and fewer than MAX_RESULTS have been emitted
  task automatic predict_outputs(input logic signed [SAMPLE_WIDTH-1:0] smp);
    logic [PHASE_WIDTH-1:0] eff_step;
    longint                 a;
    longint                 b;
    longint                 w_curr;
    longint                 acc;
    int                     n;
    interp_out_t            r;
    eff_step = (step_reg < MIN_STEP) ? PHASE_WIDTH'(MIN_STEP) : PHASE_WIDTH'(step_reg);
    hist_prev = hist_curr;
    hist_curr = smp;
    a = hist_prev;
    b = hist_curr;
    n = 0;
    while (phase_acc < PHASE_ONE && n < MAX_RESULTS) begin
      w_curr = phase_acc;
      acc = a * ((longint'(1) << PHASE_FRAC_BITS) - w_curr) + b * w_curr;
      r.sample = SAMPLE_WIDTH'(acc >>> PHASE_FRAC_BITS);
      phase_acc = phase_acc + eff_step;
      n++;
      r.last = (phase_acc >= PHASE_ONE) || (n == MAX_RESULTS);
      expected_samples.push_back(r);
    end
    if (phase_acc >= PHASE_ONE)
      phase_acc = phase_acc - PHASE_ONE;
  endtask

  always @(posedge clk) begin
    interp_out_t exp_out;
    if (rst) begin
      step_reg  = STEP_RESET;
      phase_acc = '0;
      hist_prev = '0;
      hist_curr = '0;
      expected_samples.delete();
    end else begin
      if (cfg_we)
        step_reg = cfg_wdata;
      if (src_valid && !src_stall)
        predict_outputs(source_sample);
      if (res_valid && !res_stall) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected transaction: out_sample %0d, last_of_run %0b",
                 out_sample, last_of_run);
          err_count++;
        end else begin
          exp_out = expected_samples.pop_front();
          if (out_sample !== exp_out.sample) begin
            $error("out_sample: expected %0d, got %0d", exp_out.sample, out_sample);
            err_count++;
          end
          if (last_of_run !== exp_out.last) begin
            $error("last_of_run: expected %0b, got %0b", exp_out.last, last_of_run);
            err_count++;
          end
        end
      end
    end
    outstanding <= expected_samples.size();
  end

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives source samples and step settings into the resampler under random
// idle and stall patterns; the checker beside the block judges each output.
// ----------------------------------------------------------------------------
module testbench;
  import lir_pkg::*;

  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 4000;

  logic                           clk           = 1'b0;
  logic                           rst           = 1'b1;
  logic                           cfg_we        = 1'b0;
  logic        [STEP_WIDTH-1:0]   cfg_wdata     = '0;
  logic                           src_valid     = 1'b0;
  logic                           src_stall;
  logic signed [SAMPLE_WIDTH-1:0] source_sample = '0;
  logic                           res_valid;
  logic                           res_stall     = 1'b0;
  logic signed [SAMPLE_WIDTH-1:0] out_sample;
  logic                           last_of_run;

  int mismatches;
  int outstanding;
  int src_idle_pct  = 0;
  int res_stall_pct = 0;
  int quiet_cycles  = 0;

  linear_interp_resampler_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .src_valid    (src_valid),
    .src_stall    (src_stall),
    .source_sample(source_sample),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .out_sample   (out_sample),
    .last_of_run  (last_of_run)
  );

  resample_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .src_valid    (src_valid),
    .src_stall    (src_stall),
    .source_sample(source_sample),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .out_sample   (out_sample),
    .last_of_run  (last_of_run),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    res_stall <= ($urandom_range(99) < res_stall_pct);
  end

  // ends the run when neither stream moves for too long
  always @(posedge clk) begin
    if (rst || (src_valid && !src_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  // valid stays high between back-to-back transactions
  task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] smp);
    if ($urandom_range(99) < src_idle_pct) begin
      src_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk);
    end
    src_valid     <= 1'b1;
    source_sample <= smp;
    @(posedge clk);
    while (src_stall) @(posedge clk);
  endtask

  // let every expected output drain, then cover a sample still in flight
  // that gives no output
  task automatic drain_and_settle();
    src_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_step(input logic [STEP_WIDTH-1:0] step);
    drain_and_settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= step;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_segment(input logic [STEP_WIDTH-1:0] step, input int count,
                             input int idle, input int stall, input bit pause_midway);
    logic signed [SAMPLE_WIDTH-1:0] smp;
    write_step(step);
    src_idle_pct  = idle;
    res_stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      if (pause_midway && i == count / 2)
        drain_and_settle();
      if ($urandom_range(7) == 0)
        smp = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      else
        smp = SAMPLE_WIDTH'($urandom);
      send_sample(smp);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset step is one: one output per source sample
    send_sample(16'sh0000);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(16'shffff);
    send_sample(16'sh0001);
    send_sample(16'sh5555);
    send_sample(16'shaaaa);
    // smallest legal step: 64 outputs across full-scale swings
    write_step(20'd256);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh8000);
    // steps below the floor are raised to it
    write_step(20'd0);
    send_sample(16'sh3039);
    send_sample(16'sh8000);
    write_step(20'd255);
    send_sample(16'sh7fff);
    // largest step: phase runs far above one, later samples give nothing
    write_step(20'hfffff);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh1234);
    send_sample(16'shedcb);

    run_segment(STEP_RESET, 40, 0, 0, 1'b0);
    run_segment(20'hfffff, 70, 52, 0, 1'b0);
    run_segment(20'd256, 10, 0, 52, 1'b0);
    run_segment(20'd0, 6, 29, 29, 1'b0);
    run_segment(20'd255, 6, 0, 0, 1'b0);
    run_segment(20'd20000, 50, 52, 0, 1'b1);
    run_segment(20'd8192, 40, 0, 52, 1'b0);
    run_segment(STEP_WIDTH'($urandom_range(65535, 256)), 40, 29, 29, 1'b0);
    run_segment(STEP_WIDTH'($urandom_range(20'hfffff)), 50, 0, 0, 1'b0);

    drain_and_settle();
    if (mismatches == 0 && outstanding == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
